// ----- src/mssd_pkg.sv -----
`timescale 1ns / 1ps

package mssd_pkg;

	// Defaults for the top-level parameters.
	localparam int CHANNELS_DEF  = 8;
	localparam int TIME_BITS_DEF = 32;

	// Fixed field widths.
	localparam int PIN_W   = 8;
	localparam int NOW_W   = 32;
	localparam int CFG_W   = 32;
	localparam int COUNT_W = 4;
	localparam int EVCH_W  = 3;
	localparam int SEL_W   = 4;

	// Register reset values.
	localparam logic [CFG_W-1:0]   DELAY_RESET = 32'd50;
	localparam logic [COUNT_W-1:0] COUNT_RESET = 4'd8;

	// Switch levels (active low).
	localparam logic LEVEL_LOW  = 1'b0;
	localparam logic LEVEL_HIGH = 1'b1;

	// Item commands.
	localparam logic CMD_POLL = 1'b0;
	localparam logic CMD_SCAN = 1'b1;

	// Configuration register indexes.
	localparam logic REG_DELAY = 1'b0;
	localparam logic REG_COUNT = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POLL,
		ST_SCAN,
		ST_WAIT
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;       // capture the input beat
		logic poll;       // run the poll update on the captured beat
		logic scan_emit;  // load the output register from the scan channel
		logic scan_next;  // step the scan pointer
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_scan;    // captured beat is a startup scan
		logic poll_emit;  // poll update produces a result
		logic scan_low;   // scan channel is pressed
		logic scan_end;   // scan channel is the last one in use
		logic out_last;   // held result is the final one of its beat
	} dp_stat_t;

endpackage

// ----- src/mssd_ctrl.sv -----
`timescale 1ns / 1ps

module mssd_ctrl
	import mssd_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_stall,
	output logic     out_valid,
	input  logic     out_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_stall  = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_POLL;
				end
			end
			ST_POLL: begin
				// The captured beat decides between the poll update and the scan walk.
				if (stat.is_scan) begin
					state_d = ST_SCAN;
				end else begin
					cmd.poll = 1'b1;
					state_d  = stat.poll_emit ? ST_WAIT : ST_IDLE;
				end
			end
			ST_SCAN: begin
				if (stat.scan_low) begin
					cmd.scan_emit = 1'b1;
					state_d       = ST_WAIT;
				end else if (stat.scan_end) begin
					state_d = ST_IDLE;
				end else begin
					cmd.scan_next = 1'b1;
				end
			end
			ST_WAIT: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (stat.out_last) begin
						state_d = ST_IDLE;
					end else begin
						cmd.scan_next = 1'b1;
						state_d       = ST_SCAN;
					end
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ----- src/mssd_dp.sv -----
`timescale 1ns / 1ps

module mssd_dp
	import mssd_pkg::*;
#(
	parameter int CHANNELS  = CHANNELS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dp_cmd_t            cmd,
	output dp_stat_t           stat,
	input  logic               in_cmd,
	input  logic [PIN_W-1:0]   in_levels,
	input  logic [NOW_W-1:0]   in_now,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	output logic [EVCH_W-1:0]  event_channel,
	output logic               from_startup,
	output logic               last,
	output logic [SEL_W-1:0]   selected_channel
);

	// Only the channels that have a pin bit can ever be served.
	localparam int CH_USED = (CHANNELS < PIN_W) ? CHANNELS : PIN_W;
	localparam int CI_W    = (CH_USED > 1) ? $clog2(CH_USED) : 1;
	localparam int CW      = (TIME_BITS > NOW_W) ? TIME_BITS : NOW_W;

	logic [CFG_W-1:0]     delay_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 cmd_q;
	logic [CH_USED-1:0]   lv_q;
	logic [TIME_BITS-1:0] now_q;
	logic [CI_W-1:0]      ptr_q;
	logic [CI_W-1:0]      scan_q;
	logic [CH_USED-1:0]   stable_q;
	logic [CH_USED-1:0]   armed_q;
	logic [TIME_BITS-1:0] ct_q [CH_USED];

	logic [COUNT_W-1:0]   n_eff;
	logic [CI_W-1:0]      c_poll;
	logic [CI_W-1:0]      ptr_next;
	logic                 lvl;
	logic                 changed;
	logic [TIME_BITS-1:0] elapsed;
	logic                 expired;
	logic                 later_low;
	logic [CW-1:0]        now_w;

	assign now_w = CW'(in_now);

	always_comb begin
		if (count_q == '0) begin
			n_eff = COUNT_W'(1);
		end else if (count_q > COUNT_W'(CH_USED)) begin
			n_eff = COUNT_W'(CH_USED);
		end else begin
			n_eff = count_q;
		end
	end

	// Poll channel and next pointer; a stale pointer falls back to channel 0.
	assign c_poll   = (COUNT_W'(ptr_q) < n_eff) ? ptr_q : '0;
	assign ptr_next = ((COUNT_W'(c_poll) + COUNT_W'(1)) >= n_eff) ? '0
		: CI_W'(COUNT_W'(c_poll) + COUNT_W'(1));

	assign lvl     = lv_q[c_poll];
	assign changed = lvl != stable_q[c_poll];
	assign elapsed = now_q - ct_q[c_poll];
	assign expired = CW'(elapsed) > CW'(delay_q);

	always_comb begin
		later_low = 1'b0;
		for (int i = 0; i < CH_USED; i++) begin
			if ((COUNT_W'(i) > COUNT_W'(scan_q)) && (COUNT_W'(i) < n_eff)
				&& (lv_q[i] == LEVEL_LOW)) begin
				later_low = 1'b1;
			end
		end
	end

	assign stat.is_scan   = cmd_q == CMD_SCAN;
	assign stat.poll_emit = !changed && armed_q[c_poll] && expired
		&& (stable_q[c_poll] == LEVEL_LOW);
	assign stat.scan_low  = lv_q[scan_q] == LEVEL_LOW;
	assign stat.scan_end  = (COUNT_W'(scan_q) + COUNT_W'(1)) >= n_eff;
	assign stat.out_last  = last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delay_q  <= DELAY_RESET;
			count_q  <= COUNT_RESET;
			ptr_q    <= '0;
			stable_q <= {CH_USED{LEVEL_HIGH}};
			armed_q  <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_DELAY: delay_q <= cfg_data;
					REG_COUNT: count_q <= cfg_data[COUNT_W-1:0];
					default: ;
				endcase
			end
			if (cmd.poll) begin
				ptr_q <= ptr_next;
				if (changed) begin
					stable_q[c_poll] <= lvl;
					armed_q[c_poll]  <= 1'b1;
				end else if (armed_q[c_poll] && expired) begin
					armed_q[c_poll] <= 1'b0;
				end
			end
		end
	end

	// Payload registers: captured beat, timestamps, scan pointer and result.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cmd_q  <= in_cmd;
			lv_q   <= in_levels[CH_USED-1:0];
			now_q  <= now_w[TIME_BITS-1:0];
			scan_q <= '0;
		end
		if (cmd.scan_next) begin
			scan_q <= CI_W'(COUNT_W'(scan_q) + COUNT_W'(1));
		end
		if (cmd.poll && changed) begin
			ct_q[c_poll] <= now_q;
		end
		if (cmd.poll && stat.poll_emit) begin
			event_channel    <= EVCH_W'(c_poll);
			selected_channel <= SEL_W'(c_poll);
			from_startup     <= 1'b0;
			last             <= 1'b1;
		end else if (cmd.scan_emit) begin
			event_channel    <= EVCH_W'(scan_q);
			selected_channel <= SEL_W'(scan_q);
			from_startup     <= 1'b1;
			last             <= !later_low;
		end
	end

endmodule

// ----- src/multi_switch_debounce_selector.sv -----
`timescale 1ns / 1ps
// A poll beat is captured, then the poll update either offers its result or makes the block ready again.
// A startup scan walks one channel per cycle, up to eight, pausing at each pressed channel
// while its result is offered; the output handshake stalls the walk as needed.
// The block takes one beat at a time: no new beat is accepted until the last one is through.
// Reset (arst_n low) sets all levels high, disarms all timers, clears the poll pointer and
// restores the delay to 50 ms and the channel count to 8.

module multi_switch_debounce_selector
	import mssd_pkg::*;
#(
	parameter int CHANNELS  = CHANNELS_DEF,
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              cmd,
	input  logic [PIN_W-1:0]  pin_levels,
	input  logic [NOW_W-1:0]  now_ms,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [EVCH_W-1:0] event_channel,
	output logic              from_startup,
	output logic              last,
	output logic [SEL_W-1:0]  selected_channel,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	// The controller sequences each beat: capture, then either the single poll
	// update or the scan walk, and holds each result until its beat is taken.
	dp_cmd_t  dp_cmd;
	dp_stat_t dp_stat;

	mssd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (dp_stat),
		.cmd       (dp_cmd)
	);

	// The datapath keeps the per-channel levels, timers and timestamps, and the
	// result register that drives the output payload.
	mssd_dp #(
		.CHANNELS  (CHANNELS),
		.TIME_BITS (TIME_BITS)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (dp_cmd),
		.stat             (dp_stat),
		.in_cmd           (cmd),
		.in_levels        (pin_levels),
		.in_now           (now_ms),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.event_channel    (event_channel),
		.from_startup     (from_startup),
		.last             (last),
		.selected_channel (selected_channel)
	);

	// The selected position always follows the channel of the offered result.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (selected_channel == SEL_W'(event_channel)))
		else $error("selected_channel differs from event_channel");

	// A poll result is always the only one of its beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !from_startup) |-> last)
		else $error("poll result without last");

	// A freshly accepted beat is still being worked on in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (!out_valid && in_stall))
		else $error("result offered right after acceptance");

	// After the final result of a beat is taken, the block is ready again.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall && last) |=> (!out_valid && !in_stall))
		else $error("block not idle after final result");

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps

// Testbench for the round-robin switch debouncer.
// A behavioral copy of the debouncer runs beside the block. Every input beat that the block
// accepts is fed to it, and the results it predicts are queued. A checker process compares
// every result beat the block delivers with the oldest queued prediction, field by field.
module tb;
	import mssd_pkg::*;

	// Channels that really exist, and the idle time we allow after the last expected
	// result before touching the registers.
	localparam int NCH         = CHANNELS_DEF;
	localparam int CHAN_LIM    = (NCH < 8) ? NCH : 8;
	localparam int TAIL_CYCLES = 24;
	localparam int SEG_ITEMS   = 42;

	typedef struct packed {
		logic [EVCH_W-1:0] channel;
		logic              startup;
		logic              fin;
		logic [SEL_W-1:0]  selected;
	} switch_event_t;

	logic              clk;
	logic              arst_n           = 1'b0;
	logic              in_valid         = 1'b0;
	logic              in_stall;
	logic              cmd              = CMD_POLL;
	logic [PIN_W-1:0]  pin_levels       = '1;
	logic [NOW_W-1:0]  now_ms           = '0;
	logic              out_valid;
	logic              out_stall        = 1'b0;
	logic [EVCH_W-1:0] event_channel;
	logic              from_startup;
	logic              last;
	logic [SEL_W-1:0]  selected_channel;
	logic              cfg_we           = 1'b0;
	logic              cfg_index        = REG_DELAY;
	logic [CFG_W-1:0]  cfg_data         = '0;

	// Predicted result beats, oldest first.
	switch_event_t pending_events[$];
	switch_event_t oldest_event;

	// Our own copy of the debouncer state and its registers.
	logic              stable_lvl [NCH];
	logic [NOW_W-1:0]  change_t   [NCH];
	logic              armed      [NCH];
	int                poll_ptr;
	logic [SEL_W-1:0]  sel_now;
	logic [CFG_W-1:0]  delay_ms;
	logic [COUNT_W-1:0] count_reg;

	int mismatches     = 0;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;

	multi_switch_debounce_selector u_top (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.cmd              (cmd),
		.pin_levels       (pin_levels),
		.now_ms           (now_ms),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.event_channel    (event_channel),
		.from_startup     (from_startup),
		.last             (last),
		.selected_channel (selected_channel),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop in case the block hangs on a handshake.
	initial begin
		#3_000_000;
		$display("Mismatches found");
		$finish;
	end

	task automatic reset_model();
		for (int i = 0; i < NCH; i++) begin
			stable_lvl[i] = LEVEL_HIGH;
			change_t[i]   = '0;
			armed[i]      = 1'b0;
		end
		poll_ptr  = 0;
		sel_now   = SEL_W'(8);
		delay_ms  = DELAY_RESET;
		count_reg = COUNT_RESET;
	endtask

	// A channel count of zero behaves as one, and anything above the channels that
	// exist is clipped to that number.
	function automatic int active_channels();
		int n;
		n = int'(count_reg);
		if (n < 1)
			n = 1;
		if (n > CHAN_LIM)
			n = CHAN_LIM;
		return n;
	endfunction

	task automatic push_event(input int ch, input logic startup, input logic fin);
		switch_event_t ev;
		sel_now     = SEL_W'(ch);
		ev.channel  = EVCH_W'(ch);
		ev.startup  = startup;
		ev.fin      = fin;
		ev.selected = sel_now;
		pending_events.push_back(ev);
	endtask

	// Advances our copy of the debouncer by one accepted beat and queues what it emits.
	task automatic predict_switch_events(input logic c, input logic [PIN_W-1:0] lv,
			input logic [NOW_W-1:0] t);
		int n;
		int lastlow;
		int ch;
		logic [NOW_W-1:0] elapsed;
		n = active_channels();
		if (c == CMD_SCAN) begin
			// The scan reports every pressed channel in order and leaves all state
			// except the selection untouched.
			lastlow = n;
			for (int i = 0; i < n; i++)
				if (lv[i] == LEVEL_LOW)
					lastlow = i;
			for (int i = 0; i < n; i++)
				if (lv[i] == LEVEL_LOW)
					push_event(i, 1'b1, i == lastlow);
		end else begin
			// A pointer left beyond a lowered count falls back to channel zero.
			ch = (poll_ptr < n) ? poll_ptr : 0;
			poll_ptr = (ch + 1 >= n) ? 0 : ch + 1;
			if (lv[ch] != stable_lvl[ch]) begin
				stable_lvl[ch] = lv[ch];
				change_t[ch]   = t;
				armed[ch]      = 1'b1;
			end else if (armed[ch]) begin
				// The subtraction wraps at the time width, as the block's does.
				elapsed = t - change_t[ch];
				if (elapsed > delay_ms) begin
					armed[ch] = 1'b0;
					if (stable_lvl[ch] == LEVEL_LOW)
						push_event(ch, 1'b0, 1'b1);
				end
			end
		end
	endtask

	// Offers one input beat, holds it until the block takes it, then predicts it.
	// Valid is left high on return so that back-to-back beats never drop it for
	// a single step; idle gaps and the settle task lower it.
	task automatic drive_switch_beat(input logic c, input logic [PIN_W-1:0] lv,
			input logic [NOW_W-1:0] t);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid   <= 1'b1;
		cmd        <= c;
		pin_levels <= lv;
		now_ms     <= t;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_switch_events(c, lv, t);
	endtask

	// Brings the block to rest: no beat offered, every predicted result delivered,
	// and enough extra cycles for a poll that produced nothing to finish.
	task automatic settle_block();
		in_valid <= 1'b0;
		while (pending_events.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES)
			@(posedge clk);
	endtask

	// Writes both registers on consecutive edges; the enable stays high between them.
	task automatic set_config(input logic [CFG_W-1:0] delay_val,
			input logic [COUNT_W-1:0] count_val);
		cfg_we    <= 1'b1;
		cfg_index <= REG_DELAY;
		cfg_data  <= delay_val;
		@(posedge clk);
		cfg_index <= REG_COUNT;
		cfg_data  <= CFG_W'(count_val);
		@(posedge clk);
		cfg_we   <= 1'b0;
		delay_ms  = delay_val;
		count_reg = count_val;
	endtask

	// Scans with none, all and some channels pressed under the reset settings, then a
	// press on channel zero at time zero that must still start the timer.
	task automatic test_scan_and_reset_settings();
		drive_switch_beat(CMD_SCAN, 8'hFF, 32'd0);
		drive_switch_beat(CMD_SCAN, 8'h00, 32'd0);
		drive_switch_beat(CMD_SCAN, 8'hA5, 32'd7);
		drive_switch_beat(CMD_POLL, 8'hFE, 32'd0);
		for (int i = 1; i < 8; i++)
			drive_switch_beat(CMD_POLL, 8'hFE, 32'd10);
		drive_switch_beat(CMD_POLL, 8'hFE, 32'd51);
		settle_block();
	endtask

	// A zero count acts as one channel and strands the pointer, a zero delay fires on
	// the next millisecond, and the elapsed time is taken across the wrap of the clock.
	// The upper level bits are outside the active range and must be ignored.
	task automatic test_time_edges();
		set_config(32'd0, 4'd0);
		drive_switch_beat(CMD_POLL, 8'h01, 32'hFFFF_FFF0);
		drive_switch_beat(CMD_POLL, 8'h01, 32'd5);
		drive_switch_beat(CMD_POLL, 8'hFE, 32'hFFFF_FFFF);
		drive_switch_beat(CMD_POLL, 8'hFE, 32'hFFFF_FFFF);
		drive_switch_beat(CMD_POLL, 8'hFE, 32'd0);
		settle_block();
	endtask

	// A count above the channels that exist, and the largest delay, which no elapsed
	// time can exceed.
	task automatic test_range_limits();
		set_config(32'hFFFF_FFFF, 4'd15);
		drive_switch_beat(CMD_SCAN, 8'h7F, 32'd0);
		drive_switch_beat(CMD_POLL, 8'hFF, 32'd0);
		drive_switch_beat(CMD_POLL, 8'h00, 32'd1);
		drive_switch_beat(CMD_POLL, 8'h00, 32'h8000_0000);
		settle_block();
	endtask

	// Mostly a set of switches that change now and then, polled with a slowly advancing
	// clock so that timers really expire; some bounces, scans and wild beats mixed in.
	task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
		int r;
		logic [PIN_W-1:0] sw_level;
		logic [PIN_W-1:0] lv;
		logic [NOW_W-1:0] clock_ms;
		logic [CFG_W-1:0] dly;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		sw_level = PIN_W'($urandom);
		clock_ms = $urandom;
		for (int k = 0; k < n_items; k++) begin
			if (k % SEG_ITEMS == 0) begin
				settle_block();
				r = $urandom_range(0, 9);
				if (r == 0)
					dly = $urandom;
				else if (r == 1)
					dly = '0;
				else
					dly = CFG_W'($urandom_range(1, 25));
				set_config(dly, COUNT_W'($urandom_range(0, 15)));
			end
			r = $urandom_range(0, 99);
			if (r < 8) begin
				lv = ($urandom_range(0, 1) == 0) ? sw_level : PIN_W'($urandom);
				drive_switch_beat(CMD_SCAN, lv, clock_ms);
			end else if (r < 15) begin
				// Arbitrary levels and an arbitrary jump in time.
				clock_ms = $urandom;
				drive_switch_beat(CMD_POLL, PIN_W'($urandom), clock_ms);
			end else begin
				if ($urandom_range(0, 9) == 0)
					sw_level[$urandom_range(0, PIN_W - 1)] ^= 1'b1;
				lv = sw_level;
				// A short bounce shows up on one sample only.
				if ($urandom_range(0, 19) == 0)
					lv[$urandom_range(0, PIN_W - 1)] ^= 1'b1;
				clock_ms += NOW_W'($urandom_range(0, 6));
				drive_switch_beat(CMD_POLL, lv, clock_ms);
			end
		end
		settle_block();
	endtask

	// Result checker, and the receiver's random stall.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_events.size() == 0) begin
				$error("unexpected result beat: event_channel %0d", event_channel);
				mismatches++;
			end else begin
				oldest_event = pending_events.pop_front();
				if (event_channel !== oldest_event.channel) begin
					$error("event_channel: expected %0d, actual %0d",
						oldest_event.channel, event_channel);
					mismatches++;
				end
				if (from_startup !== oldest_event.startup) begin
					$error("from_startup: expected %0d, actual %0d",
						oldest_event.startup, from_startup);
					mismatches++;
				end
				if (last !== oldest_event.fin) begin
					$error("last: expected %0d, actual %0d", oldest_event.fin, last);
					mismatches++;
				end
				if (selected_channel !== oldest_event.selected) begin
					$error("selected_channel: expected %0d, actual %0d",
						oldest_event.selected, selected_channel);
					mismatches++;
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < sink_stall_pct);
	end

	initial begin
		reset_model();
		repeat (5)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_scan_and_reset_settings();
		test_time_edges();
		test_range_limits();
		// Sender idles often, receiver stalls more; then swapped; then full speed.
		test_random_traffic(35, 72, 84);
		test_random_traffic(72, 35, 84);
		test_random_traffic(0, 0, 84);
		settle_block();
		if (mismatches == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ----- multi_switch_debounce_selector.f -----
src/mssd_pkg.sv
src/mssd_ctrl.sv
src/mssd_dp.sv
src/multi_switch_debounce_selector.sv
dv/tb.sv
